@@ src/rfid_tc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfid_tc_pkg
// Shared types and constants of the framed ASCII-hex tag checker.
// ----------------------------------------------------------------------------
package rfid_tc_pkg;

  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_END   = 8'h03;

  localparam int unsigned ID_COUNT = 4;
  localparam int unsigned ID_IDX_W = 2;
  localparam int unsigned ID_W     = 32;

  localparam logic [ID_W-1:0] ALLOWED_ID_0_RST = 32'd5902508;
  localparam logic [ID_W-1:0] ALLOWED_ID_1_RST = 32'd11690608;
  localparam logic [ID_W-1:0] ALLOWED_ID_2_RST = 32'd25698756;
  localparam logic [ID_W-1:0] ALLOWED_ID_3_RST = 32'd63598525;

  localparam logic [7:0] HEX_ALPHA_LIMIT  = 8'd64;
  localparam logic [ID_W-1:0] ALPHA_OFFSET = 32'd55;
  localparam logic [ID_W-1:0] DIGIT_OFFSET = 32'd48;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [ID_IDX_W-1:0] {
    REG_ALLOWED_ID_0 = 2'd0,
    REG_ALLOWED_ID_1 = 2'd1,
    REG_ALLOWED_ID_2 = 2'd2,
    REG_ALLOWED_ID_3 = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FOLD = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

@@ src/rfid_hex_frame_tag_checker.sv @@
// ----------------------------------------------------------------------------
// rfid_hex_frame_tag_checker
// Framed ASCII-hex tag decoder with a four-entry allow list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, rx_byte_i) takes one received byte
//   per word. STX opens or restarts a frame, bytes inside a frame are stored in
//   a DIGITS-entry character buffer, ETX closes the frame.
//   Output channel (out_valid_o / out_ready_i) carries one word per ETX:
//   tag_number_o, the buffer folded as hex digits modulo 2^32, and granted_o,
//   set when it matches one of the four allowed IDs in the APB registers.
//   Rate: a non-ETX byte takes one cycle. An ETX byte keeps in_ready_o low
//   through ST_FOLD, ST_CMP and ST_DONE until the result is loaded: one shared
//   shift-add unit folds one buffer entry a cycle, then one shared comparator
//   checks one ID a cycle. The output register lets bytes without ETX flow
//   while a result waits; a further ETX holds in the final step until the
//   receiver takes the result.
//   Reset clears frame state, the character buffer and restores the IDs.
// ----------------------------------------------------------------------------
module rfid_hex_frame_tag_checker #(
  parameter int unsigned DIGITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rfid_tc_pkg::ID_W-1:0]      tag_number_o,
  output logic                              granted_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rfid_tc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned IdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned PosW = $clog2(DIGITS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIGITS - 1);
  localparam logic [PosW-1:0] PosMax  = PosW'(DIGITS);
  localparam logic [rfid_tc_pkg::ID_IDX_W-1:0] LastId =
    rfid_tc_pkg::ID_IDX_W'(rfid_tc_pkg::ID_COUNT - 1);

  function automatic logic [rfid_tc_pkg::ID_W-1:0] digit_value(input logic [7:0] c);
    logic [rfid_tc_pkg::ID_W-1:0] ext;
    ext = {24'd0, c};
    if (c > rfid_tc_pkg::HEX_ALPHA_LIMIT) begin
      return ext - rfid_tc_pkg::ALPHA_OFFSET;
    end else begin
      return ext - rfid_tc_pkg::DIGIT_OFFSET;
    end
  endfunction

  rfid_tc_pkg::state_e state_q, state_d;

  logic                                 in_frame_q, in_frame_d;
  logic [PosW-1:0]                      wpos_q, wpos_d;
  logic [7:0]                           buf_q [DIGITS];
  logic                                 buf_we;
  logic [IdxW-1:0]                      fold_idx_q, fold_idx_d;
  logic [rfid_tc_pkg::ID_IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [rfid_tc_pkg::ID_W-1:0]         num_q, num_d;
  logic                                 hit_q, hit_d;
  logic                                 out_valid_q, out_valid_d;
  logic [rfid_tc_pkg::ID_W-1:0]         tag_number_q;
  logic                                 granted_q;
  logic                                 out_load;

  logic [rfid_tc_pkg::ID_W-1:0]         id0_q, id1_q, id2_q, id3_q;
  logic [rfid_tc_pkg::ID_W-1:0]         id_sel;
  logic                                 cfg_we;
  logic                                 in_acc;

  // APB register file
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id0_q <= rfid_tc_pkg::ALLOWED_ID_0_RST;
      id1_q <= rfid_tc_pkg::ALLOWED_ID_1_RST;
      id2_q <= rfid_tc_pkg::ALLOWED_ID_2_RST;
      id3_q <= rfid_tc_pkg::ALLOWED_ID_3_RST;
    end else if (cfg_we) begin
      unique case (rfid_tc_pkg::reg_idx_e'(paddr[3:2]))
        rfid_tc_pkg::REG_ALLOWED_ID_0: id0_q <= pwdata;
        rfid_tc_pkg::REG_ALLOWED_ID_1: id1_q <= pwdata;
        rfid_tc_pkg::REG_ALLOWED_ID_2: id2_q <= pwdata;
        rfid_tc_pkg::REG_ALLOWED_ID_3: id3_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rfid_tc_pkg::reg_idx_e'(paddr[3:2]))
      rfid_tc_pkg::REG_ALLOWED_ID_0: prdata = id0_q;
      rfid_tc_pkg::REG_ALLOWED_ID_1: prdata = id1_q;
      rfid_tc_pkg::REG_ALLOWED_ID_2: prdata = id2_q;
      rfid_tc_pkg::REG_ALLOWED_ID_3: prdata = id3_q;
      default:                       prdata = '0;
    endcase
  end

  always_comb begin
    unique case (rfid_tc_pkg::reg_idx_e'(cmp_idx_q))
      rfid_tc_pkg::REG_ALLOWED_ID_0: id_sel = id0_q;
      rfid_tc_pkg::REG_ALLOWED_ID_1: id_sel = id1_q;
      rfid_tc_pkg::REG_ALLOWED_ID_2: id_sel = id2_q;
      rfid_tc_pkg::REG_ALLOWED_ID_3: id_sel = id3_q;
      default:                       id_sel = '0;
    endcase
  end

  // Sequencer
  assign in_ready_o = (state_q == rfid_tc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    state_d     = state_q;
    in_frame_d  = in_frame_q;
    wpos_d      = wpos_q;
    buf_we      = 1'b0;
    fold_idx_d  = fold_idx_q;
    cmp_idx_d   = cmp_idx_q;
    num_d       = num_q;
    hit_d       = hit_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      rfid_tc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (rx_byte_i == rfid_tc_pkg::FRAME_START) begin
            in_frame_d = 1'b1;
            wpos_d     = '0;
          end else if (in_frame_q) begin
            if (wpos_q < PosMax) begin
              buf_we = 1'b1;
              wpos_d = wpos_q + PosW'(1);
            end
            if (rx_byte_i == rfid_tc_pkg::FRAME_END) begin
              in_frame_d = 1'b0;
              wpos_d     = '0;
              num_d      = '0;
              fold_idx_d = '0;
              state_d    = rfid_tc_pkg::ST_FOLD;
            end
          end
        end
      end
      rfid_tc_pkg::ST_FOLD: begin
        num_d = {num_q[rfid_tc_pkg::ID_W-5:0], 4'd0} + digit_value(buf_q[fold_idx_q]);
        if (fold_idx_q == LastIdx) begin
          fold_idx_d = '0;
          cmp_idx_d  = '0;
          hit_d      = 1'b0;
          state_d    = rfid_tc_pkg::ST_CMP;
        end else begin
          fold_idx_d = fold_idx_q + IdxW'(1);
        end
      end
      rfid_tc_pkg::ST_CMP: begin
        hit_d = hit_q | (num_q == id_sel);
        if (cmp_idx_q == LastId) begin
          cmp_idx_d = '0;
          state_d   = rfid_tc_pkg::ST_DONE;
        end else begin
          cmp_idx_d = cmp_idx_q + rfid_tc_pkg::ID_IDX_W'(1);
        end
      end
      rfid_tc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = rfid_tc_pkg::ST_IDLE;
        end
      end
      default: state_d = rfid_tc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfid_tc_pkg::ST_IDLE;
      in_frame_q  <= 1'b0;
      wpos_q      <= '0;
      fold_idx_q  <= '0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      wpos_q      <= wpos_d;
      fold_idx_q  <= fold_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        buf_q[i] <= '0;
      end
    end else if (buf_we) begin
      buf_q[wpos_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    if (out_load) begin
      tag_number_q <= num_q;
      granted_q    <= hit_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tag_number_o = tag_number_q;
  assign granted_o    = granted_q;

  a_wpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= PosMax)
    else $error("write position past buffer end");

  a_idle_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (wpos_q == '0))
    else $error("write position nonzero outside a frame");

  a_fold_idx_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rfid_tc_pkg::ST_FOLD) |-> (fold_idx_q == '0))
    else $error("fold index not rewound");

  a_cmp_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfid_tc_pkg::ST_FOLD && state_d == rfid_tc_pkg::ST_CMP)
      |=> (cmp_idx_q == '0 && !hit_q))
    else $error("compare pass starts dirty");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && tag_number_o == $past(num_q)))
    else $error("result word not presented");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed ASCII-hex tag checker. Bytes go in over
// a valid/ready channel with random gaps, and the IDs are written over APB
// between phases. Each result word is checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DIGITS   = 10;
  localparam int unsigned SETTLE   = 24;
  localparam int unsigned PHASE_N  = 250;

  typedef struct packed {
    logic [rfid_tc_pkg::ID_W-1:0] num;
    logic                         gr;
  } tag_word_t;

  typedef struct packed {
    logic [7:0]                   b;
    logic                         typed;
    logic [rfid_tc_pkg::ID_W-1:0] num;
    logic                         gr;
  } dir_row_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic [7:0]                         rx_byte_i   = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [rfid_tc_pkg::ID_W-1:0]       tag_number_o;
  logic                               granted_o;
  logic                               psel        = 1'b0;
  logic                               penable     = 1'b0;
  logic                               pwrite      = 1'b0;
  logic [rfid_tc_pkg::PADDR_W-1:0]    paddr       = '0;
  logic [31:0]                        pwdata      = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  logic                               frm_open;
  int unsigned                        frm_pos;
  logic [7:0]                         frm_buf [DIGITS];
  logic [rfid_tc_pkg::ID_W-1:0]       allow_id [rfid_tc_pkg::ID_COUNT];
  logic [7:0]                         id_chars [rfid_tc_pkg::ID_COUNT][DIGITS-1];

  tag_word_t            tag_q [$];
  int unsigned          mism_cnt  = 0;
  int unsigned          taken_cnt = 0;
  int unsigned          idle_in   = 0;
  int unsigned          idle_out  = 0;

  dir_row_t dir_tab [25] = '{
    '{8'h41, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_END, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_START, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_END, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_START, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_START, 1'b0, 32'h0, 1'b0},
    '{8'h46, 1'b0, 32'h0, 1'b0},
    '{8'h66, 1'b0, 32'h0, 1'b0},
    '{8'hFF, 1'b0, 32'h0, 1'b0},
    '{8'h00, 1'b0, 32'h0, 1'b0},
    '{8'h39, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_END, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_START, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{8'h30, 1'b0, 32'h0, 1'b0},
    '{rfid_tc_pkg::FRAME_END, 1'b1, 32'h0, 1'b0}
  };

  rfid_hex_frame_tag_checker #(
    .DIGITS(DIGITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tag_number_o(tag_number_o),
    .granted_o   (granted_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_out);
  end

  function automatic logic [rfid_tc_pkg::ID_W-1:0] fold_chars(input logic [7:0] cb [DIGITS]);
    logic [rfid_tc_pkg::ID_W-1:0] acc;
    logic [rfid_tc_pkg::ID_W-1:0] c;
    acc = '0;
    for (int i = 0; i < DIGITS; i++) begin
      c = {24'b0, cb[i]};
      acc = (acc << 4) + ((cb[i] > rfid_tc_pkg::HEX_ALPHA_LIMIT) ?
                          c - rfid_tc_pkg::ALPHA_OFFSET : c - rfid_tc_pkg::DIGIT_OFFSET);
    end
    return acc;
  endfunction

  // returns 1 when the byte is an STX or falls inside an open frame, i.e. is not ignored
  function automatic logic decode_byte(input logic [7:0] b, output logic has_word,
                                       output tag_word_t word);
    has_word = 1'b0;
    word     = '0;
    if (b == rfid_tc_pkg::FRAME_START) begin
      frm_open = 1'b1;
      frm_pos  = 0;
      return 1'b1;
    end
    if (!frm_open) return 1'b0;
    if (frm_pos < DIGITS) begin
      frm_buf[frm_pos] = b;
      frm_pos++;
    end
    if (b == rfid_tc_pkg::FRAME_END) begin
      frm_open = 1'b0;
      frm_pos  = 0;
      word.num = fold_chars(frm_buf);
      for (int k = 0; k < rfid_tc_pkg::ID_COUNT; k++) begin
        if (word.num == allow_id[k]) word.gr = 1'b1;
      end
      has_word = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + v[7:0];
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
  endfunction

  function automatic logic [7:0] rand_body();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return rand_hex_char();
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == rfid_tc_pkg::FRAME_START || b == rfid_tc_pkg::FRAME_END);
    return b;
  endfunction

  task automatic note_mismatch(input string what, input tag_word_t want, input tag_word_t got);
    if (mism_cnt < 10) begin
      $display("tag word error (%s): expected num=%h granted=%b, got num=%h granted=%b",
               what, want.num, want.gr, got.num, got.gr);
    end
    mism_cnt++;
  endtask

  always @(posedge clk_i) begin : result_mon
    tag_word_t want;
    tag_word_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.num = tag_number_o;
      got.gr  = granted_o;
      if (tag_q.size() == 0) begin
        note_mismatch("unexpected", '0, got);
      end else begin
        want = tag_q.pop_front();
        if (want.num !== got.num || want.gr !== got.gr) note_mismatch("value", want, got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input logic [rfid_tc_pkg::ID_W-1:0] t_num = '0,
                           input logic t_gr = 1'b0);
    logic      has_word;
    tag_word_t word;
    while ($urandom_range(0, 99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_byte(b, has_word, word)) taken_cnt++;
    if (has_word) begin
      if (typed) begin
        word.num = t_num;
        word.gr  = t_gr;
      end
      tag_q.push_back(word);
    end
  endtask

  task automatic apb_write(input rfid_tc_pkg::reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    allow_id[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (tag_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // pick IDs that some frames of the coming phase will hit
  task automatic load_ids(input int p);
    logic [7:0]                   cb [DIGITS];
    logic [rfid_tc_pkg::ID_W-1:0] ids [rfid_tc_pkg::ID_COUNT];
    drain_words();
    repeat (SETTLE) @(posedge clk_i);
    for (int k = 0; k < rfid_tc_pkg::ID_COUNT; k++) begin
      for (int i = 0; i < DIGITS - 1; i++) begin
        id_chars[k][i] = rand_hex_char();
        cb[i] = id_chars[k][i];
      end
      cb[DIGITS-1] = rfid_tc_pkg::FRAME_END;
      ids[k] = fold_chars(cb);
    end
    if (p == 1) begin
      ids[0] = '0;
      ids[3] = '1;
    end else if (p == 3) begin
      ids[0] = '1;
      ids[3] = '0;
    end
    apb_write(rfid_tc_pkg::REG_ALLOWED_ID_0, ids[0]);
    apb_write(rfid_tc_pkg::REG_ALLOWED_ID_1, ids[1]);
    apb_write(rfid_tc_pkg::REG_ALLOWED_ID_2, ids[2]);
    apb_write(rfid_tc_pkg::REG_ALLOWED_ID_3, ids[3]);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    int unsigned sel;
    int unsigned n;
    int unsigned k;
    logic        paused;
    start  = taken_cnt;
    paused = 1'b0;
    while (taken_cnt - start < budget) begin
      if (!paused && taken_cnt - start >= budget / 2) begin
        drain_words();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        k = $urandom_range(0, rfid_tc_pkg::ID_COUNT - 1);
        send_byte(rfid_tc_pkg::FRAME_START);
        for (int i = 0; i < DIGITS - 1; i++) send_byte(id_chars[k][i]);
        send_byte(rfid_tc_pkg::FRAME_END);
      end else if (sel < 85) begin
        if (sel >= 75) begin
          // open a frame and restart it
          send_byte(rfid_tc_pkg::FRAME_START);
          n = $urandom_range(0, 6);
          repeat (n) send_byte(rand_body());
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : DIGITS - 1;
        send_byte(rfid_tc_pkg::FRAME_START);
        repeat (n) send_byte(rand_body());
        send_byte(rfid_tc_pkg::FRAME_END);
      end else if (sel < 90) begin
        send_byte(rfid_tc_pkg::FRAME_START);
        n = $urandom_range(0, 12);
        repeat (n) send_byte(rand_body());
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    frm_open = 1'b0;
    frm_pos  = 0;
    for (int i = 0; i < DIGITS; i++) frm_buf[i] = '0;
    allow_id[0] = rfid_tc_pkg::ALLOWED_ID_0_RST;
    allow_id[1] = rfid_tc_pkg::ALLOWED_ID_1_RST;
    allow_id[2] = rfid_tc_pkg::ALLOWED_ID_2_RST;
    allow_id[3] = rfid_tc_pkg::ALLOWED_ID_3_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_in  = 26;
    idle_out = 84;
    foreach (dir_tab[r]) begin
      send_byte(dir_tab[r].b, dir_tab[r].typed, dir_tab[r].num, dir_tab[r].gr);
    end

    for (int p = 0; p < 6; p++) begin
      load_ids(p);
      case (p / 2)
        0: begin
          idle_in  = 26;
          idle_out = 84;
        end
        1: begin
          idle_in  = 84;
          idle_out = 26;
        end
        default: begin
          idle_in  = 0;
          idle_out = 0;
        end
      endcase
      run_phase(PHASE_N);
    end

    drain_words();
    repeat (SETTLE) @(posedge clk_i);
    if (mism_cnt == 0 && tag_q.size() == 0) begin
      $display("rfid_hex_frame_tag_checker: match");
    end else begin
      $display("rfid_hex_frame_tag_checker: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("rfid_hex_frame_tag_checker: mismatch");
    $finish;
  end

endmodule
